### hw/rtl/sgrt_pkg.sv
// Shared types, constants and helpers for the sequence gap retransmit tracker.
// Used by sgrt_ctrl, sgrt_dp and the top level; depends on nothing.
`default_nettype none

package sgrt_pkg;

  localparam int PENDING_DEPTH = 16;
  localparam int CHANNELS      = 4;

  localparam int PTR_W    = $clog2(PENDING_DEPTH);
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SRC_W    = 32;
  localparam int IDX_W    = 11;
  localparam int CNT_W    = 23;
  localparam int DIST_W   = IDX_W + 1;
  localparam int DIVC_W   = 4;

  localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(PENDING_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_LIMIT  = 23'd7255010;
  localparam logic [IDX_W-1:0]  PPF_RESET  = 11'd64;
  localparam logic [DIST_W-1:0] IDX_MOD    = 12'd2048;
  localparam logic [DIVC_W-1:0] DIV_STEPS  = DIVC_W'(DIST_W);
  localparam logic [2:0]        CH_COUNT   = 3'(CHANNELS);

  localparam logic [SRC_W-1:0] ID_CH0 = 32'd81;
  localparam logic [SRC_W-1:0] ID_CH1 = 32'd91;
  localparam logic [SRC_W-1:0] ID_CH2 = 32'd101;
  localparam logic [SRC_W-1:0] ID_CH3 = 32'd111;

  typedef enum logic [1:0] {
    KIND_NEW     = 2'd0,
    KIND_RETX    = 2'd1,
    KIND_REQ     = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_e;

  typedef enum logic {
    CFG_SAMPLING_EN = 1'b0,
    CFG_POINTS      = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_SRD, S_SCMP, S_DIV, S_INS, S_FOUT, S_RRD, S_RLD, S_ROUT
  } state_e;

  typedef struct packed {
    logic [SRC_W-1:0] source_id;
    logic [IDX_W-1:0] sample_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       channel;
    logic [SRC_W-1:0] request_source;
    logic [IDX_W-1:0] request_index;
    logic [CNT_W-1:0] frame_slot;
    logic [IDX_W-1:0] lost_frames;
    logic             table_overflow;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic [SRC_W-1:0] src;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] slot;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic do_ignore;
    logic do_first;
    logic do_hit;
    logic ptr_clr;
    logic ptr_inc;
    logic div_start;
    logic div_step;
    logic ins_init;
    logic ins_write;
    logic gap_done;
    logic load_req;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic ignore;
    logic first;
    logic hit;
    logic ptr_end;
    logic entry_valid;
    logic div_done;
    logic ins_done;
    logic full;
    logic out_last;
  } sts_t;

  // Match a source id: {known id, raw channel}
  function automatic logic [2:0] map_source(logic [SRC_W-1:0] s);
    logic [2:0] r;
    r = 3'b000;
    if (s == ID_CH0) r = 3'b100;
    else if (s == ID_CH1) r = 3'b101;
    else if (s == ID_CH2) r = 3'b110;
    else if (s == ID_CH3) r = 3'b111;
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sequence_gap_retransmit_tracker.sv
// Sequence gap tracker top: sgrt_ctrl and sgrt_dp, types from sgrt_pkg.
// An ignored or first frame has its word registered in S_DECIDE and shown in S_FOUT;
// others search the table to a hit, or divide and insert one entry per lost frame;
// inserts stop on a full table. Then each valid entry gives a request word, empties
// skipped. A new frame is taken only in S_IDLE, after the previous frame's last word.
// Reset (async, rst_ni low) clears channel counts, indices and valid bits.
`default_nettype none

module sequence_gap_retransmit_tracker import sgrt_pkg::*; (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire in_word_t         in_word_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output out_word_t             out_word_o,
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire cfg_idx_e         cfg_index_i,
  input  wire [IDX_W-1:0]       cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // Take config words at any time
  assign cfg_ready_o = 1'b1;

  sgrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sgrt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

### hw/rtl/sgrt_dp.sv
// Datapath: config registers, channel state, pending table memory, divider,
// insertion counters and the output register. Depends on sgrt_pkg.
`default_nettype none

module sgrt_dp import sgrt_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire in_word_t   in_word_i,
  input  wire             cfg_we_i,
  input  wire cfg_idx_e   cfg_index_i,
  input  wire [IDX_W-1:0] cfg_data_i,
  input  wire cmd_t       cmd_i,
  output sts_t            sts_o,
  output out_word_t       out_word_o
);

  logic                en_q;
  logic [IDX_W-1:0]    ppf_q;
  logic [SRC_W-1:0]    src_q;
  logic [IDX_W-1:0]    idx_q;
  logic [1:0]          ch_q;
  logic                mapped_q;
  logic [CNT_W-1:0]    fc_q   [CHANNELS];
  logic [IDX_W-1:0]    prev_q [CHANNELS];
  logic [PENDING_DEPTH-1:0] valid_q;
  entry_t              mem    [PENDING_DEPTH];
  entry_t              rd_q;
  logic [PTR_W-1:0]    ptr_q;
  logic [DIST_W-1:0]   rem_q, quo_q;
  logic [DIVC_W-1:0]   divc_q;
  logic [IDX_W-1:0]    lost_q, m_q, acc_idx_q;
  logic [CNT_W-1:0]    cnt_q, acc_slot_q;
  out_word_t           out_q;

  logic [CH_IDX_W-1:0] chi;
  logic [IDX_W-1:0]    step;
  logic [CNT_W-1:0]    fc_cur, fc_new;
  logic [IDX_W-1:0]    prev_cur, lost_c;
  logic [DIST_W-1:0]   diff, gap_dist;
  logic [DIST_W:0]     rem_sh;
  logic [PTR_W-1:0]    free_idx;
  logic                req_last;
  logic [2:0]          map_in, map_rd;
  logic [PENDING_DEPTH-1:0] ptr_mask;

  assign chi      = ch_q[CH_IDX_W-1:0];
  assign step     = (ppf_q == '0) ? IDX_W'(1) : ppf_q;
  assign fc_cur   = fc_q[chi];
  assign prev_cur = prev_q[chi];
  assign fc_new   = cnt_q + CNT_W'(lost_q);
  assign diff     = {1'b0, idx_q} - {1'b0, prev_cur};
  assign gap_dist = (idx_q > prev_cur) ? diff : diff + IDX_MOD;
  assign rem_sh   = {rem_q, quo_q[DIST_W-1]};
  assign lost_c   = (quo_q == '0) ? '0 : IDX_W'(quo_q - DIST_W'(1));
  assign map_in   = map_source(in_word_i.source_id);
  assign map_rd   = map_source(rd_q.src);
  assign ptr_mask = PENDING_DEPTH'(1) << ptr_q;

  // Lowest free entry and whether any entry above the pointer is valid
  always_comb begin
    free_idx = '0;
    req_last = 1'b1;
    for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = PTR_W'(i);
      if (valid_q[i] && (PTR_W'(i) > ptr_q)) req_last = 1'b0;
    end
  end

  always_comb begin
    sts_o.ignore      = !en_q || !mapped_q;
    sts_o.first       = (fc_cur == '0);
    sts_o.hit         = valid_q[ptr_q] && (rd_q.src == src_q) && (rd_q.idx == idx_q);
    sts_o.ptr_end     = (ptr_q == PTR_LAST);
    sts_o.entry_valid = valid_q[ptr_q];
    sts_o.div_done    = (divc_q == '0);
    sts_o.ins_done    = (m_q == lost_q);
    sts_o.full        = &valid_q;
    sts_o.out_last    = out_q.last;
  end

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      ppf_q <= PPF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLING_EN: en_q  <= cfg_data_i[0];
        CFG_POINTS:      ppf_q <= cfg_data_i;
        default:         en_q  <= en_q;
      endcase
    end
  end

  // Channel state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        fc_q[c]   <= '0;
        prev_q[c] <= '0;
      end
      valid_q <= '0;
    end else begin
      if (cmd_i.do_first) begin
        fc_q[chi]   <= CNT_W'(1);
        prev_q[chi] <= idx_q;
      end
      if (cmd_i.gap_done) begin
        fc_q[chi]   <= (fc_new == CNT_LIMIT) ? '0 : fc_new;
        prev_q[chi] <= idx_q;
      end
      if (cmd_i.do_hit)    valid_q[ptr_q]    <= 1'b0;
      if (cmd_i.ins_write) valid_q[free_idx] <= 1'b1;
    end
  end

  // Pending table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_write) mem[free_idx] <= '{src: src_q, idx: acc_idx_q, slot: acc_slot_q};
    rd_q <= mem[ptr_q];
  end

  // Control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      divc_q <= '0;
    end else begin
      if (cmd_i.ptr_clr)      ptr_q <= '0;
      else if (cmd_i.ptr_inc) ptr_q <= ptr_q + PTR_W'(1);
      if (cmd_i.div_start)     divc_q <= DIV_STEPS;
      else if (cmd_i.div_step) divc_q <= divc_q - DIVC_W'(1);
    end
  end

  // Input word, divider and insertion payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      src_q    <= in_word_i.source_id;
      idx_q    <= in_word_i.sample_index;
      ch_q     <= map_in[1:0];
      mapped_q <= map_in[2] && ({1'b0, map_in[1:0]} < CH_COUNT);
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= gap_dist;
      cnt_q <= fc_cur + CNT_W'(1);
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {2'b00, step}) begin
        rem_q <= DIST_W'(rem_sh - {2'b00, step});
        quo_q <= {quo_q[DIST_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DIST_W-1:0];
        quo_q <= {quo_q[DIST_W-2:0], 1'b0};
      end
    end
    if (cmd_i.ins_init) begin
      lost_q     <= lost_c;
      m_q        <= '0;
      acc_idx_q  <= prev_cur + step;
      acc_slot_q <= cnt_q;
    end else if (cmd_i.ins_write) begin
      m_q        <= m_q + IDX_W'(1);
      acc_idx_q  <= acc_idx_q + step;
      acc_slot_q <= acc_slot_q + CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_ignore) begin
      out_q <= '{kind: KIND_IGNORED, channel: ch_q, request_source: src_q,
                 request_index: idx_q, frame_slot: '0, lost_frames: '0,
                 table_overflow: 1'b0, last: ~|valid_q};
    end else if (cmd_i.do_first) begin
      out_q <= '{kind: KIND_NEW, channel: ch_q, request_source: src_q,
                 request_index: idx_q, frame_slot: CNT_W'(1), lost_frames: '0,
                 table_overflow: 1'b0, last: ~|valid_q};
    end else if (cmd_i.do_hit) begin
      out_q <= '{kind: KIND_RETX, channel: ch_q, request_source: src_q,
                 request_index: idx_q, frame_slot: rd_q.slot, lost_frames: '0,
                 table_overflow: 1'b0, last: ~|(valid_q & ~ptr_mask)};
    end else if (cmd_i.gap_done) begin
      out_q <= '{kind: KIND_NEW, channel: ch_q, request_source: src_q,
                 request_index: idx_q, frame_slot: fc_new, lost_frames: lost_q,
                 table_overflow: (m_q != lost_q), last: ~|valid_q};
    end else if (cmd_i.load_req) begin
      out_q <= '{kind: KIND_REQ, channel: map_rd[1:0], request_source: rd_q.src,
                 request_index: rd_q.idx, frame_slot: rd_q.slot, lost_frames: '0,
                 table_overflow: 1'b0, last: req_last};
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

### hw/rtl/sgrt_ctrl.sv
// Controller state machine: sequences search, divide, insert and emit steps.
// Depends on sgrt_pkg; drives sgrt_dp through cmd_t and reads sts_t.
`default_nettype none

module sgrt_ctrl import sgrt_pkg::*; (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  wire  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DECIDE;
      S_DECIDE: state_d = (sts_i.ignore || sts_i.first) ? S_FOUT : S_SRD;
      S_SRD:    state_d = S_SCMP;
      S_SCMP: begin
        if (sts_i.hit)          state_d = S_FOUT;
        else if (sts_i.ptr_end) state_d = S_DIV;
        else                    state_d = S_SRD;
      end
      S_DIV:    if (sts_i.div_done) state_d = S_INS;
      S_INS:    if (sts_i.ins_done || sts_i.full) state_d = S_FOUT;
      S_FOUT:   if (out_ready_i) state_d = sts_i.out_last ? S_IDLE : S_RRD;
      S_RRD:    if (sts_i.entry_valid) state_d = S_RLD;
      S_RLD:    state_d = S_ROUT;
      S_ROUT:   if (out_ready_i) state_d = sts_i.out_last ? S_IDLE : S_RRD;
      default:  state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      S_DECIDE: begin
        if (sts_i.ignore)     cmd_o.do_ignore = 1'b1;
        else if (sts_i.first) cmd_o.do_first  = 1'b1;
        else                  cmd_o.ptr_clr   = 1'b1;
      end
      S_SRD: ;
      S_SCMP: begin
        if (sts_i.hit)          cmd_o.do_hit    = 1'b1;
        else if (sts_i.ptr_end) cmd_o.div_start = 1'b1;
        else                    cmd_o.ptr_inc   = 1'b1;
      end
      S_DIV: begin
        if (sts_i.div_done) cmd_o.ins_init = 1'b1;
        else                cmd_o.div_step = 1'b1;
      end
      S_INS: begin
        if (sts_i.ins_done || sts_i.full) cmd_o.gap_done  = 1'b1;
        else                              cmd_o.ins_write = 1'b1;
      end
      S_FOUT: begin
        out_valid_o   = 1'b1;
        cmd_o.ptr_clr = out_ready_i;
      end
      S_RRD:  cmd_o.ptr_inc  = !sts_i.entry_valid;
      S_RLD:  cmd_o.load_req = 1'b1;
      S_ROUT: begin
        out_valid_o   = 1'b1;
        cmd_o.ptr_inc = out_ready_i && !sts_i.out_last;
      end
      default: ;
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input and output both open");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("accepted twice");

  a_div_to_ins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_done) |=> (state_q == S_INS))
    else $error("divider done not followed by insert");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.do_ignore, cmd_o.do_first, cmd_o.do_hit, cmd_o.gap_done,
              cmd_o.load_req})) else $error("output register loaded twice");

endmodule

`default_nettype wire
